FILE: sv/assert_macros.svh
// assertion macros shared by the scanner rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/jnps_pkg.sv
// types, constants and byte-class helpers for the json number policy scanner
// no dependencies; used by jnps_token_feed and json_number_policy_scanner
package jnps_pkg;

  localparam int OFFSET_BITS_DEF = 20;

  // character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_UP_N   = 8'h4E;
  localparam logic [7:0] CH_UP_I   = 8'h49;

  // special word progress codes
  localparam logic [3:0] W_IDLE     = 4'd0;
  localparam logic [3:0] W_NAN_DONE = 4'd3;
  localparam logic [3:0] W_AFTER_MINUS = 4'd4;
  localparam logic [3:0] W_AFTER_I  = 4'd5;
  localparam logic [3:0] W_INF_DONE = 4'd12;
  localparam logic [3:0] W_DEAD     = 4'd15;
  localparam logic [3:0] W_AFTER_N  = 4'd1;

  // integer digit count limits
  localparam logic [4:0] DIGITS_LIMIT = 5'd16;
  localparam logic [4:0] DIGITS_SAT   = 5'd17;

  // limit compare codes
  localparam logic [1:0] CMP_EQUAL   = 2'd0;
  localparam logic [1:0] CMP_BELOW   = 2'd1;
  localparam logic [1:0] CMP_ABOVE   = 2'd2;

  typedef enum logic [3:0] {
    G_START = 4'd0,
    G_SIGN  = 4'd1,
    G_ZERO  = 4'd2,
    G_INT   = 4'd3,
    G_DOT   = 4'd4,
    G_FRAC  = 4'd5,
    G_E     = 4'd6,
    G_ESIGN = 4'd7,
    G_EXP   = 4'd8,
    G_BAD   = 4'd9
  } gram_t;

  typedef enum logic [1:0] {
    V_OK        = 2'd0,
    V_NONFINITE = 2'd1,
    V_NEGZERO   = 2'd2,
    V_UNSAFE    = 2'd3
  } verdict_t;

  // per-token tracking state
  typedef struct packed {
    gram_t      gram;
    logic       neg;
    logic       flt;
    logic       mant_nz;
    logic [4:0] digits;
    logic [1:0] cmp;
    logic [3:0] word;
  } tok_t;

  localparam tok_t TOK_CLEAR = '{gram: G_START, neg: 1'b0, flt: 1'b0, mant_nz: 1'b0,
                                 digits: 5'd0, cmp: CMP_EQUAL, word: W_IDLE};

  function automatic logic is_boundary(logic [7:0] b);
    return b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_LBRK, CH_LBRACE, CH_COLON, CH_COMMA};
  endfunction

  function automatic logic is_delimiter(logic [7:0] b);
    return is_boundary(b) || (b == CH_RBRK) || (b == CH_RBRACE);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b inside {[CH_ZERO:CH_NINE]};
  endfunction

  // digits of 9007199254740991, most significant first
  function automatic logic [7:0] limit_digit(logic [3:0] i);
    logic [3:0] d;
    case (i)
      4'd0:  d = 4'd9;
      4'd1:  d = 4'd0;
      4'd2:  d = 4'd0;
      4'd3:  d = 4'd7;
      4'd4:  d = 4'd1;
      4'd5:  d = 4'd9;
      4'd6:  d = 4'd9;
      4'd7:  d = 4'd2;
      4'd8:  d = 4'd5;
      4'd9:  d = 4'd4;
      4'd10: d = 4'd7;
      4'd11: d = 4'd4;
      4'd12: d = 4'd0;
      4'd13: d = 4'd9;
      4'd14: d = 4'd9;
      default: d = 4'd1;
    endcase
    return CH_ZERO + {4'd0, d};
  endfunction

  // "NaN-Infinity" spelled out, indexed by word progress
  function automatic logic [7:0] word_char(logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0:  c = 8'h4E;
      4'd1:  c = 8'h61;
      4'd2:  c = 8'h4E;
      4'd3:  c = 8'h2D;
      4'd4:  c = 8'h49;
      4'd5:  c = 8'h6E;
      4'd6:  c = 8'h66;
      4'd7:  c = 8'h69;
      4'd8:  c = 8'h6E;
      4'd9:  c = 8'h69;
      4'd10: c = 8'h74;
      4'd11: c = 8'h79;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // judge a finished token
  function automatic verdict_t finish_code(tok_t t);
    verdict_t v;
    logic     ok_num;
    ok_num = (t.gram == G_ZERO) || (t.gram == G_INT) || (t.gram == G_FRAC) ||
             (t.gram == G_EXP);
    v = V_OK;
    if ((t.word == W_NAN_DONE) || (t.word == W_INF_DONE)) begin
      v = V_NONFINITE;
    end else if (ok_num) begin
      if (!t.flt) begin
        if (t.neg && (t.gram == G_ZERO)) begin
          v = V_NEGZERO;
        end else if ((t.digits > DIGITS_LIMIT) ||
                     ((t.digits == DIGITS_LIMIT) && (t.cmp == CMP_ABOVE))) begin
          v = V_UNSAFE;
        end
      end else if (t.neg && !t.mant_nz) begin
        v = V_NEGZERO;
      end
    end
    return v;
  endfunction

endpackage

FILE: sv/json_number_policy_scanner.sv
// top level of the json number policy scanner: string/escape tracking,
// token boundaries, first-offence capture and the result register
// depends on jnps_pkg, jnps_token_feed and assert_macros.svh
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_stall, in_data_byte,       | in
//          | in_end_of_text                          |
//  result  | out_valid, out_stall, out_verdict,      | out
//          | out_token_offset                        |
//
// one byte is taken per cycle while in_stall is low; the per-byte update is a single pass of
// compare and count logic into the state registers.
// a request with end_of_text set loads the result register; the verdict
// appears in the cycle after that byte is taken.
// in_stall rises only for a last byte while an earlier result is still held
// by out_stall; other bytes keep flowing.
// rst_n is synchronous; after reset and after every last byte the scanner
// is back at the start of a text.
module json_number_policy_scanner #(
  parameter int OFFSET_BITS = jnps_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_end_of_text,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_verdict,
  output logic [OFFSET_BITS-1:0] out_token_offset
);

`include "assert_macros.svh"

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  // state
  logic                   in_str_r, in_str_nxt;
  logic                   esc_r, esc_nxt;
  logic                   prev_bnd_r, prev_bnd_nxt;
  logic                   in_tok_r, in_tok_nxt;
  jnps_pkg::tok_t         tok_r, tok_nxt;
  logic [OFFSET_BITS-1:0] tok_start_r, tok_start_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  jnps_pkg::verdict_t     err_r, err_nxt;
  logic [OFFSET_BITS-1:0] err_off_r, err_off_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             verdict_r, verdict_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;

  logic           accept;
  logic           last;
  logic           delim;
  logic           consumed;
  logic           start_tok;
  logic           tok_live;
  jnps_pkg::tok_t feed_in;
  jnps_pkg::tok_t fed;

  // a last byte waits only while a held result is not taken
  assign in_stall = out_valid_r && out_stall && in_end_of_text;
  assign accept   = in_valid && !in_stall;
  assign last     = in_end_of_text;

  assign delim    = jnps_pkg::is_delimiter(in_data_byte);
  assign consumed = in_tok_r && !delim;
  assign start_tok = !in_tok_r && !in_str_r && (in_data_byte != jnps_pkg::CH_QUOTE) &&
                     prev_bnd_r &&
                     ((in_data_byte == jnps_pkg::CH_MINUS) ||
                      jnps_pkg::is_digit(in_data_byte) ||
                      (in_data_byte == jnps_pkg::CH_UP_N) ||
                      (in_data_byte == jnps_pkg::CH_UP_I));
  assign tok_live = consumed || start_tok;

  // a new token feeds its first byte from a cleared tracker
  assign feed_in = in_tok_r ? tok_r : jnps_pkg::TOK_CLEAR;

  jnps_token_feed u_feed (
    .tok_i  (feed_in),
    .byte_i (in_data_byte),
    .tok_o  (fed)
  );

  // per-byte next state
  always_comb begin
    jnps_pkg::verdict_t     fin_code;
    logic [OFFSET_BITS-1:0] fin_off;
    jnps_pkg::verdict_t     rep_code;
    logic [OFFSET_BITS-1:0] rep_off;

    in_str_nxt    = in_str_r;
    esc_nxt       = esc_r;
    prev_bnd_nxt  = prev_bnd_r;
    in_tok_nxt    = in_tok_r;
    tok_nxt       = tok_r;
    tok_start_nxt = tok_start_r;
    pos_nxt       = pos_r;
    err_nxt       = err_r;
    err_off_nxt   = err_off_r;
    verdict_nxt   = verdict_r;
    offset_nxt    = offset_r;
    fin_code      = jnps_pkg::V_OK;
    fin_off       = tok_start_r;
    rep_code      = jnps_pkg::V_OK;
    rep_off       = '0;

    // result register drains when taken
    out_valid_nxt = out_valid_r && out_stall;

    if (accept) begin
      // string and escape tracking
      if (!consumed) begin
        if (in_str_r) begin
          if (esc_r) esc_nxt = 1'b0;
          else if (in_data_byte == jnps_pkg::CH_BSLASH) esc_nxt = 1'b1;
          else if (in_data_byte == jnps_pkg::CH_QUOTE) in_str_nxt = 1'b0;
        end else if (in_data_byte == jnps_pkg::CH_QUOTE) begin
          in_str_nxt = 1'b1;
        end
      end
      prev_bnd_nxt = jnps_pkg::is_boundary(in_data_byte);

      // token tracker
      in_tok_nxt = tok_live;
      if (tok_live) tok_nxt = fed;
      if (start_tok) tok_start_nxt = pos_r;

      // a token closes at a delimiter or at the end of the text
      if (in_tok_r && delim) begin
        fin_code = jnps_pkg::finish_code(tok_r);
        fin_off  = tok_start_r;
      end else if (last && tok_live) begin
        fin_code = jnps_pkg::finish_code(fed);
        fin_off  = start_tok ? pos_r : tok_start_r;
      end

      // keep the first offence
      if ((fin_code != jnps_pkg::V_OK) && (err_r == jnps_pkg::V_OK)) begin
        err_nxt     = fin_code;
        err_off_nxt = fin_off;
      end

      if (!last) begin
        if (pos_r != POS_MAX) pos_nxt = pos_r + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
      end else begin
        // report and return to the start of a text
        if (err_nxt != jnps_pkg::V_OK) begin
          rep_code = err_nxt;
          rep_off  = err_off_nxt;
        end
        out_valid_nxt = 1'b1;
        verdict_nxt   = rep_code;
        offset_nxt    = rep_off;
        in_str_nxt    = 1'b0;
        esc_nxt       = 1'b0;
        prev_bnd_nxt  = 1'b1;
        in_tok_nxt    = 1'b0;
        tok_nxt       = jnps_pkg::TOK_CLEAR;
        tok_start_nxt = '0;
        pos_nxt       = '0;
        err_nxt       = jnps_pkg::V_OK;
        err_off_nxt   = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_str_r    <= 1'b0;
      esc_r       <= 1'b0;
      prev_bnd_r  <= 1'b1;
      in_tok_r    <= 1'b0;
      tok_r       <= jnps_pkg::TOK_CLEAR;
      tok_start_r <= '0;
      pos_r       <= '0;
      err_r       <= jnps_pkg::V_OK;
      err_off_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_str_r    <= in_str_nxt;
      esc_r       <= esc_nxt;
      prev_bnd_r  <= prev_bnd_nxt;
      in_tok_r    <= in_tok_nxt;
      tok_r       <= tok_nxt;
      tok_start_r <= tok_start_nxt;
      pos_r       <= pos_nxt;
      err_r       <= err_nxt;
      err_off_r   <= err_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
    offset_r  <= offset_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = verdict_r;
  assign out_token_offset = offset_r;

  // checks
  `ASSERT_IMPL(a_ok_has_zero_offset, out_valid_r && (verdict_r == jnps_pkg::V_OK), offset_r == '0)
  `ASSERT_NEXT(a_last_gives_result, accept && last, out_valid_r)
  `ASSERT_NEXT(a_last_clears_text, accept && last, !in_tok_r && !in_str_r && (pos_r == '0))
  `ASSERT_IMPL(a_stall_only_when_held, in_stall, out_valid_r && out_stall)

endmodule

FILE: sv/jnps_token_feed.sv
// one-byte update of the token tracker: number grammar, digit limit check
// and special word match; depends on jnps_pkg
module jnps_token_feed (
  input  jnps_pkg::tok_t tok_i,
  input  logic [7:0]     byte_i,
  output jnps_pkg::tok_t tok_o
);

  logic is_dig;
  logic is_e;

  // word match and number grammar
  always_comb begin
    logic add_digit;
    tok_o     = tok_i;
    add_digit = 1'b0;
    is_dig    = jnps_pkg::is_digit(byte_i);
    is_e      = (byte_i == jnps_pkg::CH_UP_E) || (byte_i == jnps_pkg::CH_LO_E);

    // special words
    if (tok_i.word == jnps_pkg::W_IDLE) begin
      if (byte_i == jnps_pkg::CH_UP_N) tok_o.word = jnps_pkg::W_AFTER_N;
      else if (byte_i == jnps_pkg::CH_MINUS) tok_o.word = jnps_pkg::W_AFTER_MINUS;
      else if (byte_i == jnps_pkg::CH_UP_I) tok_o.word = jnps_pkg::W_AFTER_I;
      else tok_o.word = jnps_pkg::W_DEAD;
    end else if ((tok_i.word == jnps_pkg::W_NAN_DONE) ||
                 (tok_i.word >= jnps_pkg::W_INF_DONE)) begin
      tok_o.word = jnps_pkg::W_DEAD;
    end else if (byte_i == jnps_pkg::word_char(tok_i.word)) begin
      tok_o.word = tok_i.word + 4'd1;
    end else begin
      tok_o.word = jnps_pkg::W_DEAD;
    end

    // number grammar
    case (tok_i.gram)
      jnps_pkg::G_START, jnps_pkg::G_SIGN: begin
        if ((tok_i.gram == jnps_pkg::G_START) && (byte_i == jnps_pkg::CH_MINUS)) begin
          tok_o.neg  = 1'b1;
          tok_o.gram = jnps_pkg::G_SIGN;
        end else if (is_dig) begin
          add_digit = 1'b1;
          if (byte_i == jnps_pkg::CH_ZERO) begin
            tok_o.gram = jnps_pkg::G_ZERO;
          end else begin
            tok_o.gram    = jnps_pkg::G_INT;
            tok_o.mant_nz = 1'b1;
          end
        end else begin
          tok_o.gram = jnps_pkg::G_BAD;
        end
      end
      jnps_pkg::G_ZERO, jnps_pkg::G_INT: begin
        if (is_dig && (tok_i.gram == jnps_pkg::G_INT)) begin
          add_digit = 1'b1;
        end else if (byte_i == jnps_pkg::CH_DOT) begin
          tok_o.flt  = 1'b1;
          tok_o.gram = jnps_pkg::G_DOT;
        end else if (is_e) begin
          tok_o.flt  = 1'b1;
          tok_o.gram = jnps_pkg::G_E;
        end else begin
          tok_o.gram = jnps_pkg::G_BAD;
        end
      end
      jnps_pkg::G_DOT, jnps_pkg::G_FRAC: begin
        if (is_dig) begin
          if (byte_i != jnps_pkg::CH_ZERO) tok_o.mant_nz = 1'b1;
          tok_o.gram = jnps_pkg::G_FRAC;
        end else if (is_e && (tok_i.gram == jnps_pkg::G_FRAC)) begin
          tok_o.flt  = 1'b1;
          tok_o.gram = jnps_pkg::G_E;
        end else begin
          tok_o.gram = jnps_pkg::G_BAD;
        end
      end
      jnps_pkg::G_E: begin
        if ((byte_i == jnps_pkg::CH_PLUS) || (byte_i == jnps_pkg::CH_MINUS)) begin
          tok_o.gram = jnps_pkg::G_ESIGN;
        end else if (is_dig) begin
          tok_o.gram = jnps_pkg::G_EXP;
        end else begin
          tok_o.gram = jnps_pkg::G_BAD;
        end
      end
      jnps_pkg::G_ESIGN, jnps_pkg::G_EXP: begin
        tok_o.gram = is_dig ? jnps_pkg::G_EXP : jnps_pkg::G_BAD;
      end
      default: begin
        tok_o.gram = jnps_pkg::G_BAD;
      end
    endcase

    // integer digit against 9007199254740991, digit by digit
    if (add_digit) begin
      if ((tok_i.digits < jnps_pkg::DIGITS_LIMIT) && (tok_i.cmp == jnps_pkg::CMP_EQUAL)) begin
        if (byte_i < jnps_pkg::limit_digit(tok_i.digits[3:0])) begin
          tok_o.cmp = jnps_pkg::CMP_BELOW;
        end else if (byte_i > jnps_pkg::limit_digit(tok_i.digits[3:0])) begin
          tok_o.cmp = jnps_pkg::CMP_ABOVE;
        end
      end
      if (tok_i.digits < jnps_pkg::DIGITS_SAT) tok_o.digits = tok_i.digits + 5'd1;
    end
  end

endmodule
